// ----- rtl/lhbp_pkg.sv -----
// lhbp_pkg: shared constants and helpers for the local-history branch predictor.
// No dependencies.

package lhbp_pkg;

	// Command codes carried on the input tuser
	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	localparam int unsigned PC_W   = 32;
	localparam int unsigned CTR_W  = 2;

	// Counter reset value: weakly not taken
	localparam logic [CTR_W-1:0] CTR_INIT = 2'd1;
	localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
	localparam logic [CTR_W-1:0] CTR_MIN  = 2'd0;

	localparam logic [PC_W-1:0] PC_STEP = 32'd4;

	// Saturating two-bit counter step
	function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] ctr,
	                                              input logic            tk);
		logic [CTR_W-1:0] res;
		res = ctr;
		if (tk) begin
			if (ctr != CTR_MAX) res = ctr + CTR_W'(1);
		end else begin
			if (ctr != CTR_MIN) res = ctr - CTR_W'(1);
		end
		return res;
	endfunction

endpackage

// ----- rtl/lhbp_ram.sv -----
// lhbp_ram: generic single-write, single-read synchronous RAM.
// Read data registered, held while no read is issued. No dependencies.

module lhbp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ----- rtl/local_history_branch_predictor_unit.sv -----
// local_history_branch_predictor_unit: top level of the two-level local-history
// branch predictor with BTB. Depends on lhbp_pkg and lhbp_ram.
//
//  channel  dir  tdata (lsb first)                                  tuser
//  s_axis   in   pc[31:0], actual_target[63:32], taken[64], pad     cmd
//  m_axis   out  predicted_pc[31:0], predicted_taken[32], pad       -
//
// Each transaction passes three steps: accept and read history + BTB, read the
// counter table at the local history, then resolve and write back. The counter
// read depends on the history read, so it waits for the registered history data.
// After reset a clearing pass over max(BTB_ENTRIES, HISTORY_ENTRIES,
// 2**HISTORY_BITS) entries initialises all three RAMs; no input is taken then.
// The result register lets the next input be accepted while a result waits;
// the resolve step waits only if the result register is still occupied.

module local_history_branch_predictor_unit #(
	parameter int unsigned BTB_ENTRIES     = 256,
	parameter int unsigned HISTORY_ENTRIES = 256,
	parameter int unsigned HISTORY_BITS    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // pc, actual_target, taken, zero pad
	input  logic [0:0]  s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // predicted_pc, predicted_taken, zero pad
);

	import lhbp_pkg::*;

	localparam int unsigned BTB_AW   = $clog2(BTB_ENTRIES);
	localparam int unsigned HIST_AW  = $clog2(HISTORY_ENTRIES);
	localparam int unsigned PHT_SIZE = 1 << HISTORY_BITS;
	localparam int unsigned TAG_W    = PC_W - BTB_AW - 2;
	localparam int unsigned BTB_W    = 1 + TAG_W + PC_W;  // {valid, tag, target}

	localparam int unsigned CLR_A     = (BTB_ENTRIES > HISTORY_ENTRIES) ?
	                                    BTB_ENTRIES : HISTORY_ENTRIES;
	localparam int unsigned CLR_DEPTH = (CLR_A > PHT_SIZE) ? CLR_A : PHT_SIZE;
	localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

	localparam logic [BTB_AW-1:0]  BTB_MASK  = BTB_AW'(BTB_ENTRIES - 1);
	localparam logic [HIST_AW-1:0] HIST_MASK = HIST_AW'(HISTORY_ENTRIES - 1);
	localparam logic [CLR_W-1:0]   CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

	// Sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_HIST  = 2'd2;
	localparam logic [1:0] ST_PHT   = 2'd3;

	logic [1:0]       state_q;
	logic [CLR_W-1:0] clr_q;

	// Captured transaction
	logic                    cmd_q;
	logic [PC_W-1:0]         pc_q;
	logic [PC_W-1:0]         target_q;
	logic                    taken_q;
	logic [BTB_AW-1:0]       btb_idx_q;
	logic [HIST_AW-1:0]      hist_idx_q;
	logic [HISTORY_BITS-1:0] pht_idx_q;

	// Result register
	logic            m_valid_q;
	logic [PC_W-1:0] m_pc_q;
	logic            m_taken_q;

	// Input field unpacking
	logic [PC_W-1:0] in_pc;
	logic [PC_W-1:0] in_target;
	logic            in_taken;
	logic            s_fire;
	logic            resolve;
	logic            clearing;

	assign in_pc     = s_axis_tdata[31:0];
	assign in_target = s_axis_tdata[63:32];
	assign in_taken  = s_axis_tdata[64];

	assign clearing      = (state_q == ST_CLEAR);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign resolve       = (state_q == ST_PHT) && (!m_valid_q || m_axis_tready);

	// RAM ports
	logic                    btb_we, hist_we, pht_we;
	logic [BTB_AW-1:0]       btb_waddr;
	logic [HIST_AW-1:0]      hist_waddr;
	logic [HISTORY_BITS-1:0] pht_waddr;
	logic [BTB_W-1:0]        btb_wdata, btb_rdata;
	logic [HISTORY_BITS-1:0] hist_wdata, hist_rdata;
	logic [CTR_W-1:0]        pht_wdata, pht_rdata;
	logic [BTB_AW-1:0]       in_btb_idx;
	logic [HIST_AW-1:0]      in_hist_idx;

	assign in_btb_idx  = in_pc[2 +: BTB_AW] & BTB_MASK;
	assign in_hist_idx = in_pc[2 +: HIST_AW] & HIST_MASK;

	// Resolve-stage decode
	logic              rd_valid;
	logic [TAG_W-1:0]  rd_tag;
	logic [PC_W-1:0]   rd_target;
	logic [TAG_W-1:0]  cur_tag;
	logic              pred_taken;
	logic              btb_hit;
	logic [PC_W-1:0]   next_pc;
	logic              do_update;

	assign {rd_valid, rd_tag, rd_target} = btb_rdata;
	assign cur_tag    = pc_q[PC_W-1 -: TAG_W];
	assign pred_taken = pht_rdata[CTR_W-1];        // counter above one
	assign btb_hit    = rd_valid && (rd_tag == cur_tag);
	assign next_pc    = (pred_taken && btb_hit) ? rd_target : (pc_q + PC_STEP);
	assign do_update  = resolve && (cmd_q == CMD_UPDATE);

	// Write muxing: clearing pass, else the update write-back
	always_comb begin
		if (clearing) begin
			btb_we     = (32'(clr_q) < 32'(BTB_ENTRIES));
			hist_we    = (32'(clr_q) < 32'(HISTORY_ENTRIES));
			pht_we     = (32'(clr_q) < 32'(PHT_SIZE));
			btb_waddr  = clr_q[BTB_AW-1:0];
			hist_waddr = clr_q[HIST_AW-1:0];
			pht_waddr  = clr_q[HISTORY_BITS-1:0];
			btb_wdata  = '0;
			hist_wdata = '0;
			pht_wdata  = CTR_INIT;
		end else begin
			btb_we     = do_update && taken_q;
			hist_we    = do_update;
			pht_we     = do_update;
			btb_waddr  = btb_idx_q;
			hist_waddr = hist_idx_q;
			pht_waddr  = pht_idx_q;
			btb_wdata  = {1'b1, cur_tag, target_q};
			hist_wdata = HISTORY_BITS'({hist_rdata, taken_q});  // shift in outcome
			pht_wdata  = ctr_step(pht_rdata, taken_q);
		end
	end

	lhbp_ram #(.WIDTH(BTB_W), .DEPTH(BTB_ENTRIES)) u_btb (
		.clk   (clk),
		.we    (btb_we),
		.waddr (btb_waddr),
		.wdata (btb_wdata),
		.re    (s_fire),
		.raddr (in_btb_idx),
		.rdata (btb_rdata)
	);

	lhbp_ram #(.WIDTH(HISTORY_BITS), .DEPTH(HISTORY_ENTRIES)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (s_fire),
		.raddr (in_hist_idx),
		.rdata (hist_rdata)
	);

	// Pattern table is indexed by the local history alone
	lhbp_ram #(.WIDTH(CTR_W), .DEPTH(PHT_SIZE)) u_pht (
		.clk   (clk),
		.we    (pht_we),
		.waddr (pht_waddr),
		.wdata (pht_wdata),
		.re    (state_q == ST_HIST),
		.raddr (hist_rdata),
		.rdata (pht_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_LAST) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_fire) state_q <= ST_HIST;
				end
				ST_HIST: begin
					state_q <= ST_PHT;
				end
				ST_PHT: begin
					if (resolve) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Transaction payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q      <= s_axis_tuser[0];
			pc_q       <= in_pc;
			target_q   <= in_target;
			taken_q    <= in_taken;
			btb_idx_q  <= in_btb_idx;
			hist_idx_q <= in_hist_idx;
		end
		if (state_q == ST_HIST) pht_idx_q <= hist_rdata;
	end

	// Result register; update transactions return zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (resolve) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resolve) begin
			if (cmd_q == CMD_PREDICT) begin
				m_pc_q    <= next_pc;
				m_taken_q <= pred_taken;
			end else begin
				m_pc_q    <= '0;
				m_taken_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, m_taken_q, m_pc_q};

endmodule
